[rtl/shpd_pkg.sv]
// Shared types, codes and constants for the sync header packet deframer.
`timescale 1ns / 1ps
package shpd_pkg;

  localparam int TICK_COUNT_WIDTH = 16;
  localparam int TIMEOUT_W        = 16;
  localparam int PKT_SIZE_W       = 9;
  localparam int POS_W            = 9;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 16;
  localparam int TICK_CMP_W       = (TICK_COUNT_WIDTH > TIMEOUT_W) ? TICK_COUNT_WIDTH
                                                                   : TIMEOUT_W;

  localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

  // Commands
  localparam logic [1:0] CMD_ARM  = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_BYTE    = 2'd0;
  localparam logic [1:0] ST_LAST    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKT = 1'd1;

  // Reset values and protocol constants
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd100;
  localparam logic [PKT_SIZE_W-1:0] MAX_PKT_RST  = 9'd255;
  localparam logic [PKT_SIZE_W-1:0] MIN_PKT_SIZE = 9'd11;
  localparam logic [15:0]           LEN_MIN      = 16'd4;
  localparam logic [15:0]           LEN_MAX      = 16'd250;
  localparam logic [PKT_SIZE_W-1:0] PKT_OVERHEAD = 9'd7;
  localparam logic [7:0]            SYNC_FF      = 8'hFF;
  localparam logic [7:0]            SYNC_FD      = 8'hFD;
  localparam logic [7:0]            SYNC_00      = 8'h00;
  localparam logic [POS_W-1:0]      POS_BODY     = 9'd4;
  localparam logic [POS_W-1:0]      POS_LEN_LO   = 9'd5;
  localparam logic [POS_W-1:0]      POS_LEN_HI   = 9'd6;
  localparam logic [POS_W-1:0]      POS_PAYLOAD  = 9'd7;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       packet_byte;
    logic [POS_W-1:0] position;
  } res_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0]  timeout_ticks;
    logic [PKT_SIZE_W-1:0] max_packet_size;
  } cfg_t;

endpackage

[rtl/shpd_if.sv]
// Channel interfaces: input items, result items and register writes.
`timescale 1ns / 1ps
interface shpd_in_if import shpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface shpd_out_if import shpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [7:0]       packet_byte;
  logic [POS_W-1:0] position;
  modport source (output valid, output status, output packet_byte, output position,
                  input ready);
  modport sink   (input valid, input status, input packet_byte, input position,
                  output ready);
endinterface

interface shpd_cfg_if import shpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/sync_header_packet_deframer_top.sv]
// Path order: an accepted input transaction waits in the input register, and its result
//   is valid on the output once the result register has been loaded with it.
// Throughput: one input transaction per cycle unless stalled; the path holds an input
//   register, one pass of deframer logic and a result register.
// in_ch.ready falls only when the input register holds a result-bearing item
//   and the result register is full and not being drained.
// Reset (rst_n low at a clock edge) disarms the receiver, empties both registers and
//   restores timeout_ticks = 100 and max_packet_size = 255.
`timescale 1ns / 1ps
module sync_header_packet_deframer_top import shpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  shpd_in_if.sink    in_ch,
  shpd_out_if.source out_ch,
  shpd_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  item_t in_item;
  item_t item;
  res_t  res;
  res_t  out_res;
  logic  item_vld;
  logic  take;
  logic  res_vld;
  logic  slot_free;

  // Register writes are always taken; send them only while the block is idle (not enforced here).
  assign cfg_ch.ready = 1'b1;

  shpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  assign in_item.command = in_ch.command;
  assign in_item.rx_byte = in_ch.rx_byte;

  // Capture the transaction; hold it while the core stalls.
  shpd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  // Hunt, position tracking, length check and idle timer in one pass.
  shpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_vld  (item_vld),
    .item      (item),
    .slot_free (slot_free),
    .take      (take),
    .res_vld   (res_vld),
    .res       (res)
  );

  // Park the result until downstream takes it; refill in the same cycle it drains.
  shpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.status      = out_res.status;
  assign out_ch.packet_byte = out_res.packet_byte;
  assign out_ch.position    = out_res.position;

endmodule

[rtl/shpd_cfg_regs.sv]
// Configuration registers: timeout and largest packet size.
`timescale 1ns / 1ps
module shpd_cfg_regs import shpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  logic [TIMEOUT_W-1:0]  timeout_r;
  logic [PKT_SIZE_W-1:0] max_pkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      max_pkt_r <= MAX_PKT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_TIMEOUT: timeout_r <= wr_data[TIMEOUT_W-1:0];
        CFG_MAX_PKT: max_pkt_r <= wr_data[PKT_SIZE_W-1:0];
        default:     ;
      endcase
    end
  end

  assign cfg.timeout_ticks   = timeout_r;
  assign cfg.max_packet_size = max_pkt_r;

endmodule

[rtl/shpd_in_stage.sv]
// Input register: holds one accepted transaction until the core takes it.
`timescale 1ns / 1ps
module shpd_in_stage import shpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  input  logic  take,
  output logic  item_vld,
  output item_t item
);

  logic  vld_r;
  item_t item_r;

  assign in_ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

[rtl/shpd_core.sv]
// Deframer state: header hunt, packet position, length check and idle timer.
`timescale 1ns / 1ps
module shpd_core import shpd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  item_vld,
  input  item_t item,
  input  logic  slot_free,
  output logic  take,
  output logic  res_vld,
  output res_t  res
);

  localparam logic [1:0] HUNT_START = 2'd0;
  localparam logic [1:0] HUNT_FF1   = 2'd1;
  localparam logic [1:0] HUNT_FF2   = 2'd2;
  localparam logic [1:0] HUNT_FD    = 2'd3;

  logic                        armed_r,   armed_nxt;
  logic [1:0]                  hunt_r,    hunt_nxt;
  logic                        in_body_r, in_body_nxt;
  logic [POS_W-1:0]            pos_r,     pos_nxt;
  logic [7:0]                  len_lo_r,  len_lo_nxt;
  logic [PKT_SIZE_W-1:0]       total_r,   total_nxt;
  logic [TICK_COUNT_WIDTH-1:0] idle_r,    idle_nxt;

  logic                        emit;
  logic [TICK_COUNT_WIDTH-1:0] idle_inc;
  logic [15:0]                 len;
  logic [PKT_SIZE_W-1:0]       size;
  logic [PKT_SIZE_W-1:0]       total_eff;
  logic [POS_W:0]              pos_plus1;

  assign idle_inc  = (idle_r == TICK_MAX) ? idle_r : idle_r + 1'b1;
  assign len       = {item.rx_byte, len_lo_r};
  assign size      = {1'b0, len_lo_r} + PKT_OVERHEAD;
  assign total_eff = (pos_r == POS_LEN_HI) ? size : total_r;
  assign pos_plus1 = {1'b0, pos_r} + 1'b1;

  always_comb begin
    armed_nxt   = armed_r;
    hunt_nxt    = hunt_r;
    in_body_nxt = in_body_r;
    pos_nxt     = pos_r;
    len_lo_nxt  = len_lo_r;
    total_nxt   = total_r;
    idle_nxt    = idle_r;
    emit        = 1'b0;
    res         = '0;

    case (item.command)
      CMD_ARM: begin
        // Drop any partial packet and start a fresh hunt; reject the arm if max size is too small.
        armed_nxt   = 1'b0;
        hunt_nxt    = HUNT_START;
        in_body_nxt = 1'b0;
        pos_nxt     = '0;
        total_nxt   = '0;
        idle_nxt    = '0;
        if (cfg.max_packet_size < MIN_PKT_SIZE) begin
          emit       = 1'b1;
          res.status = ST_REJECT;
        end else begin
          armed_nxt = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (armed_r) begin
          idle_nxt = '0;
          if (!in_body_r) begin
            unique case (hunt_r)
              HUNT_START: hunt_nxt = (item.rx_byte == SYNC_FF) ? HUNT_FF1 : HUNT_START;
              HUNT_FF1:   hunt_nxt = (item.rx_byte == SYNC_FF) ? HUNT_FF2 : HUNT_START;
              HUNT_FF2: begin
                if (item.rx_byte == SYNC_FD) begin
                  hunt_nxt = HUNT_FD;
                end else if (item.rx_byte == SYNC_FF) begin
                  hunt_nxt = HUNT_FF2;
                end else begin
                  hunt_nxt = HUNT_START;
                end
              end
              HUNT_FD: begin
                hunt_nxt = HUNT_START;
                if (item.rx_byte == SYNC_00) begin
                  in_body_nxt = 1'b1;
                  pos_nxt     = POS_BODY;
                end
              end
              default: hunt_nxt = HUNT_START;
            endcase
          end else begin
            emit = 1'b1;
            if (pos_r == POS_LEN_LO) begin
              len_lo_nxt = item.rx_byte;
            end
            if (pos_r == POS_LEN_HI &&
                (len < LEN_MIN || len > LEN_MAX || size > cfg.max_packet_size)) begin
              armed_nxt   = 1'b0;
              in_body_nxt = 1'b0;
              hunt_nxt    = HUNT_START;
              res.status  = ST_REJECT;
            end else begin
              if (pos_r == POS_LEN_HI) begin
                total_nxt = size;
              end
              res.packet_byte = item.rx_byte;
              res.position    = pos_r;
              if (pos_r >= POS_PAYLOAD && pos_plus1 >= {1'b0, total_eff}) begin
                armed_nxt   = 1'b0;
                in_body_nxt = 1'b0;
                hunt_nxt    = HUNT_START;
                res.status  = ST_LAST;
              end else begin
                pos_nxt    = pos_plus1[POS_W-1:0];
                res.status = ST_BYTE;
              end
            end
          end
        end
      end
      CMD_TICK: begin
        if (armed_r) begin
          idle_nxt = idle_inc;
          if (TICK_CMP_W'(idle_inc) >= TICK_CMP_W'(cfg.timeout_ticks) ||
              idle_inc == TICK_MAX) begin
            armed_nxt   = 1'b0;
            in_body_nxt = 1'b0;
            hunt_nxt    = HUNT_START;
            emit        = 1'b1;
            res.status  = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance unless a result would land on a full output register.
  assign take    = item_vld && (!emit || slot_free);
  assign res_vld = take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      hunt_r    <= HUNT_START;
      in_body_r <= 1'b0;
      pos_r     <= '0;
      total_r   <= '0;
      idle_r    <= '0;
    end else if (take) begin
      armed_r   <= armed_nxt;
      hunt_r    <= hunt_nxt;
      in_body_r <= in_body_nxt;
      pos_r     <= pos_nxt;
      total_r   <= total_nxt;
      idle_r    <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      len_lo_r <= len_lo_nxt;
    end
  end

  a_body_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> armed_r)
    else $error("packet body tracked while disarmed");

  a_body_no_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (hunt_r == HUNT_START))
    else $error("header hunt active inside packet body");

  a_body_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_body_r |-> (pos_r >= POS_BODY))
    else $error("body position below first post-header byte");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(armed_r) && $stable(pos_r) && $stable(idle_r))
    else $error("state moved without taking a transaction");

endmodule

[rtl/shpd_out_stage.sv]
// Result register: holds one result transaction until downstream takes it.
`timescale 1ns / 1ps
module shpd_out_stage import shpd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  output logic slot_free,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic vld_r;
  res_t res_r;

  assign slot_free = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

[sim/tb_sync_header_packet_deframer_top.sv]
// Self-checking testbench for the sync header packet deframer top level.
`timescale 1ns / 1ps
module tb_sync_header_packet_deframer_top;
  import shpd_pkg::*;

  // Command code the block ignores; the package names only the three live ones.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Run guard: far above the slowest legal run under the longest stalls.
  localparam int CYCLE_LIMIT = 200_000;
  // Cycles to let pass after the last result before touching registers.
  localparam int SETTLE_CYCLES = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  shpd_in_if  in_ch ();
  shpd_out_if out_ch ();
  shpd_cfg_if cfg_ch ();

  sync_header_packet_deframer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Result channel ready, driven from one process only.
  logic res_ready = 1'b0;
  assign out_ch.ready = res_ready;

  // ---------------------------------------------------------------------------
  // Deframer predictor: its own copy of the registers and receiver state.
  // ---------------------------------------------------------------------------
  logic [TIMEOUT_W-1:0]        p_timeout  = TIMEOUT_RST;
  logic [PKT_SIZE_W-1:0]       p_max_size = MAX_PKT_RST;
  logic                        p_armed    = 1'b0;
  logic [1:0]                  p_hunt     = 2'd0;   // header bytes matched so far
  logic                        p_in_body  = 1'b0;
  logic [POS_W-1:0]            p_pos      = '0;
  logic [7:0]                  p_len_lo   = '0;
  logic [PKT_SIZE_W-1:0]       p_total    = '0;
  logic [TICK_COUNT_WIDTH-1:0] p_idle     = '0;

  res_t expected_results [$];   // predicted results, oldest first
  int   errors     = 0;
  int   live_items = 0;         // accepted input transactions
  int   cycle_count = 0;
  bit   no_gaps    = 1'b0;      // both sides run flat out while set
  int   sink_wait  = 0;
  int   sink_draw;
  res_t got;
  res_t want;

  // Directed stimulus table; typed rows carry their expected result.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       typed;
    res_t       res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_BYTE,   8'hFF, 1'b0, '0},                        // byte while disarmed
    '{CMD_UNUSED, 8'h5A, 1'b0, '0},                        // unused command
    '{CMD_ARM,    8'h00, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 1'b0, '0},                        // hunt waits for FF
    '{CMD_BYTE,   8'hFF, 1'b0, '0},
    '{CMD_BYTE,   8'h12, 1'b0, '0},                        // non-FF after first FF
    '{CMD_BYTE,   8'hFF, 1'b0, '0},
    '{CMD_BYTE,   8'hFF, 1'b0, '0},
    '{CMD_BYTE,   8'hFF, 1'b0, '0},                        // repeated FF holds phase
    '{CMD_BYTE,   8'hFD, 1'b0, '0},
    '{CMD_BYTE,   8'h80, 1'b0, '0},                        // bad fourth byte
    '{CMD_ARM,    8'hFF, 1'b0, '0},                        // arm while armed
    '{CMD_BYTE,   8'hFF, 1'b0, '0},
    '{CMD_BYTE,   8'hFF, 1'b0, '0},
    '{CMD_BYTE,   8'hFD, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 1'b0, '0},                        // header found
    '{CMD_BYTE,   8'hFF, 1'b1, '{ST_BYTE, 8'hFF, 9'd4}},   // id
    '{CMD_BYTE,   8'h04, 1'b1, '{ST_BYTE, 8'h04, 9'd5}},   // length low: shortest
    '{CMD_BYTE,   8'h00, 1'b1, '{ST_BYTE, 8'h00, 9'd6}},   // length high
    '{CMD_BYTE,   8'h00, 1'b1, '{ST_BYTE, 8'h00, 9'd7}},
    '{CMD_TICK,   8'hFF, 1'b0, '0},                        // tick mid-packet
    '{CMD_BYTE,   8'hFF, 1'b1, '{ST_BYTE, 8'hFF, 9'd8}},
    '{CMD_BYTE,   8'hA5, 1'b1, '{ST_BYTE, 8'hA5, 9'd9}},
    '{CMD_BYTE,   8'h5A, 1'b1, '{ST_LAST, 8'h5A, 9'd10}},  // eleventh byte ends it
    '{CMD_TICK,   8'h00, 1'b0, '0}                         // tick while disarmed
  };

  // Drop the current read: hunt restarts, body state clears.
  function automatic void disarm_rx();
    p_armed   = 1'b0;
    p_in_body = 1'b0;
    p_hunt    = 2'd0;
  endfunction

  // Advance the predictor by one accepted item; return 1 when a result follows.
  function automatic bit deframe_predict(input logic [1:0] cmd, input logic [7:0] b,
                                         output res_t r);
    logic [15:0]      len;
    logic [16:0]      size;
    logic [POS_W-1:0] pos;
    r = '0;
    if (cmd == CMD_ARM) begin
      disarm_rx();
      p_pos   = '0;
      p_total = '0;
      p_idle  = '0;
      if (p_max_size < MIN_PKT_SIZE) begin
        r.status = ST_REJECT;
        return 1'b1;
      end
      p_armed = 1'b1;
      return 1'b0;
    end
    if (!p_armed) return 1'b0;
    if (cmd == CMD_BYTE) begin
      p_idle = '0;
      if (!p_in_body) begin
        // Header hunt: FF FF FD 00, with FF repeats held at the third byte.
        case (p_hunt)
          2'd0: p_hunt = (b == SYNC_FF) ? 2'd1 : 2'd0;
          2'd1: p_hunt = (b == SYNC_FF) ? 2'd2 : 2'd0;
          2'd2: begin
            if (b == SYNC_FD) p_hunt = 2'd3;
            else if (b == SYNC_FF) p_hunt = 2'd2;
            else p_hunt = 2'd0;
          end
          default: begin
            p_hunt = 2'd0;
            if (b == SYNC_00) begin
              p_in_body = 1'b1;
              p_pos     = POS_BODY;
            end
          end
        endcase
        return 1'b0;
      end
      pos = p_pos;
      if (pos == POS_LEN_LO) p_len_lo = b;
      if (pos == POS_LEN_HI) begin
        len  = {b, p_len_lo};
        size = {1'b0, len} + 17'(PKT_OVERHEAD);
        if (len < LEN_MIN || len > LEN_MAX || size > 17'(p_max_size)) begin
          disarm_rx();
          r.status = ST_REJECT;
          return 1'b1;
        end
        p_total = size[PKT_SIZE_W-1:0];
      end
      r.packet_byte = b;
      r.position    = pos;
      if (pos >= POS_PAYLOAD && ({1'b0, pos} + 10'd1) >= {1'b0, p_total}) begin
        disarm_rx();
        r.status = ST_LAST;
        return 1'b1;
      end
      p_pos    = pos + 9'd1;
      r.status = ST_BYTE;
      return 1'b1;
    end
    if (cmd == CMD_TICK) begin
      // Saturating idle count; either limit ends the read.
      if (p_idle != TICK_MAX) p_idle = p_idle + 1'b1;
      if (p_idle >= p_timeout || p_idle == TICK_MAX) begin
        disarm_rx();
        r.status = ST_TIMEOUT;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= 200) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls per transaction, check each accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
      sink_wait <= 0;
    end else if (res_ready) begin
      if (out_ch.valid) begin
        got = '{out_ch.status, out_ch.packet_byte, out_ch.position};
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result st=%0d byte=%02h pos=%0d",
                                  got.status, got.packet_byte, got.position));
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status || got.packet_byte != want.packet_byte ||
              got.position != want.position) begin
            flag_mismatch($sformatf("got st=%0d byte=%02h pos=%0d, want st=%0d byte=%02h pos=%0d",
                                    got.status, got.packet_byte, got.position,
                                    want.status, want.packet_byte, want.position));
          end
        end
        // Draw the stall before the next transaction.
        sink_draw = no_gaps ? 0 : $urandom_range(0, 6);
        sink_wait <= sink_draw;
        res_ready <= (sink_draw == 0);
      end
    end else if (sink_wait <= 1) begin
      res_ready <= 1'b1;
      sink_wait <= 0;
    end else begin
      sink_wait <= sink_wait - 1;
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Drive one transaction and predict it once accepted. Valid stays high into
  // the next item unless that item draws a gap, so it never toggles within a step.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                           input bit fixed = 1'b0, input res_t fixed_res = '0);
    int   gap;
    bit   hit;
    res_t pred;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    live_items++;
    hit = deframe_predict(cmd, b, pred);
    if (fixed) expected_results.push_back(fixed_res);
    else if (hit) expected_results.push_back(pred);
  endtask

  // Hold input idle until every result is in, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_xfer(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_TIMEOUT) p_timeout = val;
    else p_max_size = val[PKT_SIZE_W-1:0];
  endtask

  // Write one or both registers back to back, then release the channel.
  task automatic program_regs(input bit wr_timeout, input logic [15:0] timeout_val,
                              input bit wr_max, input logic [8:0] max_val);
    if (wr_timeout) cfg_xfer(CFG_TIMEOUT, timeout_val);
    if (wr_max) cfg_xfer(CFG_MAX_PKT, CFG_DATA_W'(max_val));
    cfg_ch.valid <= 1'b0;
  endtask

  // Bytes leaning toward the header values so noise can fake partial headers.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0: return SYNC_FF;
      1: return SYNC_FD;
      2: return SYNC_00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly short legal lengths; sometimes the edges and illegal values.
  function automatic int pick_length();
    case ($urandom_range(0, 19))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(251, 255);
      2: return ($urandom_range(1, 255) << 8) | $urandom_range(0, 255);
      3: return 250;
      4: return $urandom_range(4, 250);
      default: return $urandom_range(4, 12);
    endcase
  endfunction

  // One random sequence: usually arm + header + packet with random content,
  // otherwise noise, broken headers, bad lengths, timeouts or early re-arms.
  task automatic send_packet_burst();
    logic [7:0] hdr [4];
    int kind;
    int len;
    int body_len;
    int stall_at;
    int stall;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) send_item(2'($urandom_range(0, 3)), noise_byte());
      return;
    end
    if (kind != 1) send_item(CMD_ARM, 8'($urandom));
    hdr = '{SYNC_FF, SYNC_FF, SYNC_FD, SYNC_00};
    if ($urandom_range(0, 6) == 0) hdr[$urandom_range(0, 3)] = 8'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, noise_byte());
    end
    foreach (hdr[i]) send_item(CMD_BYTE, hdr[i]);
    len = pick_length();
    send_item(CMD_BYTE, 8'($urandom));       // id
    send_item(CMD_BYTE, 8'(len));
    send_item(CMD_BYTE, 8'(len >> 8));
    body_len = (len >= 4 && len <= 250) ? len : $urandom_range(0, 4);
    // Now and then sit idle right at (or one short of) the timeout.
    stall = int'(p_timeout) - int'($urandom_range(0, 1));
    if (stall < 0) stall = 0;
    stall_at = (p_timeout <= 300 && $urandom_range(0, 7) == 0) ?
               $urandom_range(0, body_len) : -1;
    for (int i = 0; i <= body_len; i++) begin
      if (i == stall_at) begin
        repeat (stall) send_item(CMD_TICK, 8'($urandom));
      end else if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2)) send_item(CMD_TICK, 8'($urandom));
      end
      if (i == body_len) break;
      if ($urandom_range(0, 39) == 0) begin
        send_item(CMD_ARM, 8'($urandom));    // abandon the packet midway
        break;
      end
      send_item(CMD_BYTE, 8'($urandom));
    end
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = live_items + n;
    while (live_items < stop_at) send_packet_burst();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_TICK;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_TIMEOUT;
    cfg_ch.data   <= '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk at reset register values.
    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].cmd, dir_rows[k].data, dir_rows[k].typed, dir_rows[k].res);
    end
    run_random(300);
    drain();

    // Tightest settings: any tick times out, only length 4 fits.
    program_regs(1'b1, 16'd1, 1'b1, 9'd11);
    run_random(300);
    drain();

    // Widest settings: length 250 fits, the longest idle allowed.
    program_regs(1'b1, 16'hFFFF, 1'b1, 9'd257);
    run_random(300);
    drain();
    // Run flat out on both sides: no gaps, no stalls.
    no_gaps = 1'b1;
    run_random(100);
    drain();
    no_gaps = 1'b0;

    // Zero timeout: the first tick ends the read; max size above the 257 cap.
    program_regs(1'b1, 16'd0, 1'b1, 9'd300);
    run_random(150);
    drain();

    // Max size below the smallest packet: every arm is rejected.
    program_regs(1'b0, 16'd0, 1'b1, 9'd10);
    run_random(40);
    drain();

    // All-ones max size with a short random timeout.
    program_regs(1'b1, 16'($urandom_range(2, 40)), 1'b1, 9'h1FF);
    run_random(300);
    drain();

    // Random legal settings.
    program_regs(1'b1, 16'($urandom_range(1, 300)), 1'b1, 9'($urandom_range(11, 257)));
    run_random(250);
    drain();

    if (expected_results.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
